FILE: hdl/tzhf_pkg.sv
`default_nettype none

package tzhf_pkg;

   // field widths
   localparam int unsigned TempWidth  = 10;
   localparam int unsigned DutyWidth  = 9;
   localparam int unsigned ZoneWidth  = 3;
   localparam int unsigned IndexWidth = 3;

   // quotient of every ramp is below 250, so eight divider steps suffice
   localparam int unsigned QuotWidth  = 8;
   localparam int unsigned ProdWidth  = TempWidth + QuotWidth;

   // duty constants
   localparam logic [DutyWidth-1:0] DUTY_FULL = 9'd499;
   localparam logic [DutyWidth-1:0] DUTY_MID  = 9'd249;
   localparam logic [QuotWidth-1:0] RAMP_HIGH = 8'd250;
   localparam logic [QuotWidth-1:0] RAMP_LOW  = 8'd249;

   // threshold reset values
   localparam logic [TempWidth-1:0] VERY_COLD_RESET    = 10'd41;
   localparam logic [TempWidth-1:0] COLD_RESET         = 10'd51;
   localparam logic [TempWidth-1:0] COMFORT_LOW_RESET  = 10'd61;
   localparam logic [TempWidth-1:0] COMFORT_HIGH_RESET = 10'd72;
   localparam logic [TempWidth-1:0] WARM_RESET         = 10'd82;
   localparam logic [TempWidth-1:0] HOT_RESET          = 10'd102;

   typedef enum logic [ZoneWidth-1:0] {
      ZONE_VERY_COLD    = 3'd0,
      ZONE_COLD         = 3'd1,
      ZONE_NEAR_COMFORT = 3'd2,
      ZONE_COMFORT      = 3'd3,
      ZONE_WARMING      = 3'd4,
      ZONE_WARM         = 3'd5,
      ZONE_HOT          = 3'd6
   } zone_type;

   typedef enum logic [IndexWidth-1:0] {
      CSR_VERY_COLD    = 3'd0,
      CSR_COLD         = 3'd1,
      CSR_COMFORT_LOW  = 3'd2,
      CSR_COMFORT_HIGH = 3'd3,
      CSR_WARM         = 3'd4,
      CSR_HOT          = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TempWidth-1:0] very_cold;
      logic [TempWidth-1:0] cold;
      logic [TempWidth-1:0] comfort_low;
      logic [TempWidth-1:0] comfort_high;
      logic [TempWidth-1:0] warm;
      logic [TempWidth-1:0] hot;
   } limits_type;

   // data carried from cell to cell; word holds the unused dividend bits
   // on the left and the quotient bits gathered so far on the right
   typedef struct packed {
      zone_type             zone;
      logic [TempWidth-1:0] rem;
      logic [QuotWidth-1:0] word;
      logic [TempWidth-1:0] divisor;
   } div_data_type;

endpackage

`default_nettype wire

FILE: hdl/temp_zone_heater_fan_duty_core.sv
// Temperature zone to heater and fan duty mapper.
//
// Request channel (req_valid / req_ready / req_temp_sample) takes one 10-bit
// temperature sample per request. Response channel (rsp_valid / rsp_ready)
// returns the heater duty, the fan duty (0..499, 499 is full on) and the zone
// code for each request, in request order.
// Six thresholds are written through the csr_ port (index 0 very cold ..
// 5 hot); indexes 6 and 7 are ignored. csr_ready is always high. Write them
// only while no request is in flight.
// Pipeline: two front stages (zone compare, scaling multiply), eight
// restoring divider cells, one output register. Throughput is one request
// per cycle while rsp_ready is high; the divider is a row of cells that
// each retire one quotient bit.
// Reset returns the thresholds to 41, 51, 61, 72, 82, 102 and empties the
// pipeline. When rsp_ready is low the response holds; empty slots in the
// pipeline still fill, and req_ready drops only once every stage is full.
`default_nettype none

module temp_zone_heater_fan_duty_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tzhf_pkg::IndexWidth-1:0]      csr_index,
   input  wire logic [tzhf_pkg::TempWidth-1:0]       csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tzhf_pkg::TempWidth-1:0]       req_temp_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [tzhf_pkg::DutyWidth-1:0]            rsp_heater_pwm,
   output logic [tzhf_pkg::DutyWidth-1:0]            rsp_fan_pwm,
   output logic [tzhf_pkg::ZoneWidth-1:0]            rsp_zone
);

   localparam int unsigned Steps = tzhf_pkg::QuotWidth;

   tzhf_pkg::limits_type             limits_ff, limits_in;
   logic [Steps:0]                   chain_vld;
   logic [Steps:0]                   chain_ready;
   tzhf_pkg::div_data_type           chain_data [Steps+1];

   logic                             rsp_vld_ff, rsp_vld_in;
   logic [tzhf_pkg::DutyWidth-1:0]   heater_ff, heater_in;
   logic [tzhf_pkg::DutyWidth-1:0]   fan_ff, fan_in;
   tzhf_pkg::zone_type               zone_ff;
   logic                             out_ready;
   logic [tzhf_pkg::QuotWidth-1:0]   quot;

   // threshold registers
   assign csr_ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         case (tzhf_pkg::csr_index_type'(csr_index))
            tzhf_pkg::CSR_VERY_COLD:    limits_in.very_cold    = csr_wdata;
            tzhf_pkg::CSR_COLD:         limits_in.cold         = csr_wdata;
            tzhf_pkg::CSR_COMFORT_LOW:  limits_in.comfort_low  = csr_wdata;
            tzhf_pkg::CSR_COMFORT_HIGH: limits_in.comfort_high = csr_wdata;
            tzhf_pkg::CSR_WARM:         limits_in.warm         = csr_wdata;
            tzhf_pkg::CSR_HOT:          limits_in.hot          = csr_wdata;
            default:                    limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.very_cold    <= tzhf_pkg::VERY_COLD_RESET;
         limits_ff.cold         <= tzhf_pkg::COLD_RESET;
         limits_ff.comfort_low  <= tzhf_pkg::COMFORT_LOW_RESET;
         limits_ff.comfort_high <= tzhf_pkg::COMFORT_HIGH_RESET;
         limits_ff.warm         <= tzhf_pkg::WARM_RESET;
         limits_ff.hot          <= tzhf_pkg::HOT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // zone compare and scaling
   tzhf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .limits   (limits_ff),
      .up_vld   (req_valid),
      .up_temp  (req_temp_sample),
      .up_ready (req_ready),
      .dn_vld   (chain_vld[0]),
      .dn_data  (chain_data[0]),
      .dn_ready (chain_ready[0])
   );

   // divider row, one quotient bit per cell
   for (genvar i = 0; i < Steps; i++) begin : g_cell
      tzhf_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_vld   (chain_vld[i]),
         .up_data  (chain_data[i]),
         .up_ready (chain_ready[i]),
         .dn_vld   (chain_vld[i+1]),
         .dn_data  (chain_data[i+1]),
         .dn_ready (chain_ready[i+1])
      );
   end

   assign out_ready          = !rsp_vld_ff || rsp_ready;
   assign chain_ready[Steps] = out_ready;

   // map zone and quotient onto the two duties
   always_comb begin
      quot       = chain_data[Steps].word;
      heater_in  = '0;
      fan_in     = '0;
      rsp_vld_in = out_ready ? chain_vld[Steps] : rsp_vld_ff;
      case (chain_data[Steps].zone)
         tzhf_pkg::ZONE_VERY_COLD: heater_in = tzhf_pkg::DUTY_FULL;
         tzhf_pkg::ZONE_COLD:
            heater_in = tzhf_pkg::DUTY_FULL - tzhf_pkg::DutyWidth'(quot);
         tzhf_pkg::ZONE_NEAR_COMFORT: heater_in = tzhf_pkg::DutyWidth'(quot);
         tzhf_pkg::ZONE_WARMING:      fan_in    = tzhf_pkg::DutyWidth'(quot);
         tzhf_pkg::ZONE_WARM:
            fan_in = tzhf_pkg::DUTY_MID + tzhf_pkg::DutyWidth'(quot);
         tzhf_pkg::ZONE_HOT:          fan_in    = tzhf_pkg::DUTY_FULL;
         default: begin
            heater_in = '0;
            fan_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         heater_ff <= heater_in;
         fan_ff    <= fan_in;
         zone_ff   <= chain_data[Steps].zone;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_heater_pwm = heater_ff;
   assign rsp_fan_pwm    = fan_ff;
   assign rsp_zone       = zone_ff;

   // heater and fan never run together
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (heater_ff == '0) || (fan_ff == '0))
      else $error("heater and fan both on");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (heater_ff <= tzhf_pkg::DUTY_FULL) && (fan_ff <= tzhf_pkg::DUTY_FULL))
      else $error("duty above full scale");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (zone_ff == tzhf_pkg::ZONE_COMFORT) |-> (heater_ff == '0) && (fan_ff == '0))
      else $error("comfort zone with output on");

endmodule

`default_nettype wire

FILE: hdl/tzhf_front.sv
`default_nettype none

module tzhf_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tzhf_pkg::limits_type                limits,
   input  wire logic                                up_vld,
   input  wire logic [tzhf_pkg::TempWidth-1:0]      up_temp,
   output logic                                     up_ready,
   output logic                                     dn_vld,
   output tzhf_pkg::div_data_type                   dn_data,
   input  wire logic                                dn_ready
);

   // stage A: zone decision, difference and divisor
   logic                                a_vld_ff, a_vld_in;
   tzhf_pkg::zone_type                  a_zone_ff, a_zone_in;
   logic [tzhf_pkg::TempWidth-1:0]      a_diff_ff, a_diff_in;
   logic [tzhf_pkg::TempWidth-1:0]      a_div_ff, a_div_in;
   logic                                a_high_ff, a_high_in;
   logic                                a_ready;

   // stage B: scaled dividend
   logic                                b_vld_ff, b_vld_in;
   tzhf_pkg::div_data_type              b_data_ff, b_data_in;
   logic                                b_ready;
   logic [tzhf_pkg::ProdWidth-1:0]      prod;
   logic [tzhf_pkg::QuotWidth-1:0]      ramp;

   assign b_ready  = !b_vld_ff || dn_ready;
   assign a_ready  = !a_vld_ff || b_ready;
   assign up_ready = a_ready;

   // priority compare of the sample against the thresholds
   always_comb begin
      a_vld_in  = a_ready ? up_vld : a_vld_ff;
      a_zone_in = tzhf_pkg::ZONE_HOT;
      a_diff_in = '0;
      a_div_in  = tzhf_pkg::TempWidth'(1);
      a_high_in = 1'b0;
      if (up_temp < limits.very_cold) begin
         a_zone_in = tzhf_pkg::ZONE_VERY_COLD;
      end else if (up_temp < limits.cold) begin
         a_zone_in = tzhf_pkg::ZONE_COLD;
         a_diff_in = up_temp - limits.very_cold;
         a_div_in  = limits.cold - limits.very_cold;
         a_high_in = 1'b1;
      end else if (up_temp < limits.comfort_low) begin
         a_zone_in = tzhf_pkg::ZONE_NEAR_COMFORT;
         a_diff_in = limits.comfort_low - up_temp;
         a_div_in  = limits.comfort_low - limits.cold;
      end else if (up_temp <= limits.comfort_high) begin
         a_zone_in = tzhf_pkg::ZONE_COMFORT;
      end else if (up_temp < limits.warm) begin
         a_zone_in = tzhf_pkg::ZONE_WARMING;
         a_diff_in = up_temp - limits.comfort_high;
         a_div_in  = limits.warm - limits.comfort_high;
      end else if (up_temp < limits.hot) begin
         a_zone_in = tzhf_pkg::ZONE_WARM;
         a_diff_in = up_temp - limits.warm;
         a_div_in  = limits.hot - limits.warm;
         a_high_in = 1'b1;
      end
   end

   // scale the difference by the ramp height
   always_comb begin
      ramp = a_high_ff ? tzhf_pkg::RAMP_HIGH : tzhf_pkg::RAMP_LOW;
      prod = {{tzhf_pkg::QuotWidth{1'b0}}, a_diff_ff}
           * {{tzhf_pkg::TempWidth{1'b0}}, ramp};
      b_vld_in          = b_ready ? a_vld_ff : b_vld_ff;
      b_data_in.zone    = a_zone_ff;
      b_data_in.rem     = prod[tzhf_pkg::ProdWidth-1:tzhf_pkg::QuotWidth];
      b_data_in.word    = prod[tzhf_pkg::QuotWidth-1:0];
      b_data_in.divisor = a_div_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_zone_ff <= a_zone_in;
         a_diff_ff <= a_diff_in;
         a_div_ff  <= a_div_in;
         a_high_ff <= a_high_in;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign dn_vld  = b_vld_ff;
   assign dn_data = b_data_ff;

   // the difference never exceeds the divisor (equal at the bottom of the
   // near-comfort ramp), which keeps the quotient in range
   assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |-> (a_diff_ff <= a_div_ff))
      else $error("ramp difference above divisor");

   assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (b_data_ff.rem < b_data_ff.divisor))
      else $error("dividend exceeds quotient range");

   assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !b_ready |=> a_vld_ff)
      else $error("stalled request dropped in front stage");

endmodule

`default_nettype wire

FILE: hdl/tzhf_div_cell.sv
`default_nettype none

module tzhf_div_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    up_vld,
   input  wire tzhf_pkg::div_data_type  up_data,
   output logic                         up_ready,
   output logic                         dn_vld,
   output tzhf_pkg::div_data_type       dn_data,
   input  wire logic                    dn_ready
);

   logic                             vld_ff, vld_in;
   tzhf_pkg::div_data_type           data_ff, data_in;
   logic [tzhf_pkg::TempWidth:0]     trial;
   logic [tzhf_pkg::TempWidth:0]     wide_div;
   logic [tzhf_pkg::TempWidth:0]     diff;
   logic                             ge;

   assign up_ready = !vld_ff || dn_ready;

   // one restoring step: shift in the next dividend bit, try a subtract
   always_comb begin
      trial    = {up_data.rem, up_data.word[tzhf_pkg::QuotWidth-1]};
      wide_div = {1'b0, up_data.divisor};
      diff     = trial - wide_div;
      ge       = (trial >= wide_div);
      data_in.zone    = up_data.zone;
      data_in.divisor = up_data.divisor;
      data_in.rem     = ge ? diff[tzhf_pkg::TempWidth-1:0]
                           : trial[tzhf_pkg::TempWidth-1:0];
      data_in.word    = {up_data.word[tzhf_pkg::QuotWidth-2:0], ge};
      vld_in          = up_ready ? up_vld : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_data = data_ff;

   // partial remainder always stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (data_ff.rem < data_ff.divisor))
      else $error("partial remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      vld_ff && !dn_ready |=> vld_ff && $stable(data_ff))
      else $error("stalled cell lost its contents");

endmodule

`default_nettype wire
